### rtl/core/stpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the spanning-tree port engine.
// No dependencies; every other file of the block imports this package.
package stpe_pkg;

    localparam int PORT_SLOTS = 6;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] port_t;
    typedef logic [PORT_SLOTS-1:0] mask_t;

    localparam cmd_t CMD_RESET   = 2'd0;
    localparam cmd_t CMD_REQUEST = 2'd1;
    localparam cmd_t CMD_ACCEPT  = 2'd2;
    localparam cmd_t CMD_REJECT  = 2'd3;

    typedef struct packed {
        port_t index;
        mask_t rest;
    } pick_t;

endpackage

### rtl/core/stpe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received and sent tree-control messages.
// Depends on stpe_pkg for the field types.
interface stpe_in_if;
    import stpe_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  command;
    port_t arrival_port;
    mask_t connected_ports;

    modport source (output valid, output command, output arrival_port,
                    output connected_ports, input ready);
    modport sink (input valid, input command, input arrival_port,
                  input connected_ports, output ready);
endinterface

interface stpe_out_if;
    import stpe_pkg::*;

    logic  valid;
    logic  ready;
    port_t send_port;
    cmd_t  send_command;
    logic  last_of_run;
    logic  has_parent;
    port_t parent_index;
    mask_t child_mask;

    modport source (output valid, output send_port, output send_command,
                    output last_of_run, output has_parent, output parent_index,
                    output child_mask, input ready);
    modport sink (input valid, input send_port, input send_command,
                  input last_of_run, input has_parent, input parent_index,
                  input child_mask, output ready);
endinterface

### rtl/core/stpe_pick.sv
`timescale 1ns / 1ps
// Lowest-set-bit finder shared by every flood run of the sequencer.
// Depends on stpe_pkg for the mask and result types.
module stpe_pick (
    input  stpe_pkg::mask_t mask,
    output stpe_pkg::pick_t pick
);
    import stpe_pkg::*;

    always_comb
    begin
        pick.index = '0;
        for (int i = PORT_SLOTS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                pick.index = port_t'(i);
            end
        end
        pick.rest = mask & (mask - mask_t'(1));
    end

endmodule

### rtl/core/spanning_tree_port_engine.sv
`timescale 1ns / 1ps
// Spanning-tree port engine: one received message is taken at a time. A parent
// request, once accepted, makes the block send requests to the other connected
// ports, then the accept; a request from a second parent gets a reject, and a
// tree reset floods a clear to every connected port but the parent. The single
// lowest-set-bit unit walks the port mask, one message per cycle unless the sink
// stalls. Child accepts only update the child mask; received rejects and other
// ignored messages send nothing. Messages are emitted only when the output
// register is free, so a stalled sink stretches a run accordingly.
module spanning_tree_port_engine #(
    parameter int PORT_COUNT = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    stpe_in_if.sink           msg_in,
    stpe_out_if.source        msg_out
);
    import stpe_pkg::*;

    localparam int ScanPorts = (PORT_COUNT < PORT_SLOTS) ? PORT_COUNT : PORT_SLOTS;
    localparam mask_t UsableMask = (mask_t'(1) << ScanPorts) - mask_t'(1);
    localparam port_t ScanLimit = port_t'(ScanPorts);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLOOD = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       held_reg, held_next;
    port_t      parent_reg, parent_next;
    mask_t      children_reg, children_next;
    mask_t      mask_reg, mask_next;
    cmd_t       flood_cmd_reg, flood_cmd_next;
    logic       tail_en_reg, tail_en_next;
    cmd_t       tail_cmd_reg, tail_cmd_next;
    port_t      tail_port_reg, tail_port_next;

    logic       out_valid_reg, out_valid_next;
    port_t      out_port_reg, out_port_next;
    cmd_t       out_cmd_reg, out_cmd_next;
    logic       out_last_reg, out_last_next;
    logic       out_held_reg, out_held_next;
    port_t      out_parent_reg, out_parent_next;
    mask_t      out_children_reg, out_children_next;

    pick_t      pick;
    logic       emit_ok;
    logic       port_ok;
    mask_t      arrival_bit;
    mask_t      parent_bit;

    stpe_pick u_pick (
        .mask (mask_reg),
        .pick (pick)
    );

    assign msg_in.ready = (state_reg == ST_IDLE);
    assign emit_ok = !out_valid_reg || msg_out.ready;
    assign port_ok = (msg_in.arrival_port < ScanLimit);

    always_comb
    begin
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            arrival_bit[i] = (msg_in.arrival_port == port_t'(i));
            parent_bit[i]  = (parent_reg == port_t'(i));
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        held_next         = held_reg;
        parent_next       = parent_reg;
        children_next     = children_reg;
        mask_next         = mask_reg;
        flood_cmd_next    = flood_cmd_reg;
        tail_en_next      = tail_en_reg;
        tail_cmd_next     = tail_cmd_reg;
        tail_port_next    = tail_port_reg;
        out_valid_next    = out_valid_reg && !msg_out.ready;
        out_port_next     = out_port_reg;
        out_cmd_next      = out_cmd_reg;
        out_last_next     = out_last_reg;
        out_held_next     = out_held_reg;
        out_parent_next   = out_parent_reg;
        out_children_next = out_children_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_in.valid)
                begin
                    case (msg_in.command)
                        CMD_REQUEST:
                        begin
                            if (port_ok)
                            begin
                                tail_port_next = msg_in.arrival_port;
                                if (!held_reg || parent_reg == msg_in.arrival_port)
                                begin
                                    held_next      = 1'b1;
                                    parent_next    = msg_in.arrival_port;
                                    mask_next      = msg_in.connected_ports & UsableMask
                                                     & ~arrival_bit;
                                    flood_cmd_next = CMD_REQUEST;
                                    tail_en_next   = 1'b1;
                                    tail_cmd_next  = CMD_ACCEPT;
                                    state_next     = (|mask_next) ? ST_FLOOD : ST_TAIL;
                                end
                                else
                                begin
                                    tail_cmd_next = CMD_REJECT;
                                    state_next    = ST_TAIL;
                                end
                            end
                        end
                        CMD_ACCEPT:
                        begin
                            if (port_ok)
                            begin
                                children_next = children_reg | arrival_bit;
                            end
                        end
                        CMD_RESET:
                        begin
                            if (held_reg)
                            begin
                                mask_next      = msg_in.connected_ports & UsableMask
                                                 & ~parent_bit;
                                flood_cmd_next = CMD_RESET;
                                tail_en_next   = 1'b0;
                                held_next      = 1'b0;
                                parent_next    = '0;
                                children_next  = '0;
                                state_next     = (|mask_next) ? ST_FLOOD : ST_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FLOOD:
            begin
                if (emit_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_port_next     = pick.index;
                    out_cmd_next      = flood_cmd_reg;
                    out_last_next     = !(|pick.rest) && !tail_en_reg;
                    out_held_next     = held_reg;
                    out_parent_next   = held_reg ? parent_reg : '0;
                    out_children_next = children_reg;
                    mask_next         = pick.rest;
                    if (!(|pick.rest))
                    begin
                        state_next = tail_en_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (emit_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_port_next     = tail_port_reg;
                    out_cmd_next      = tail_cmd_reg;
                    out_last_next     = 1'b1;
                    out_held_next     = held_reg;
                    out_parent_next   = held_reg ? parent_reg : '0;
                    out_children_next = children_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= 1'b0;
            parent_reg    <= '0;
            children_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            parent_reg    <= parent_next;
            children_reg  <= children_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg         <= mask_next;
        flood_cmd_reg    <= flood_cmd_next;
        tail_en_reg      <= tail_en_next;
        tail_cmd_reg     <= tail_cmd_next;
        tail_port_reg    <= tail_port_next;
        out_port_reg     <= out_port_next;
        out_cmd_reg      <= out_cmd_next;
        out_last_reg     <= out_last_next;
        out_held_reg     <= out_held_next;
        out_parent_reg   <= out_parent_next;
        out_children_reg <= out_children_next;
    end

    assign msg_out.valid        = out_valid_reg;
    assign msg_out.send_port    = out_port_reg;
    assign msg_out.send_command = out_cmd_reg;
    assign msg_out.last_of_run  = out_last_reg;
    assign msg_out.has_parent   = out_held_reg;
    assign msg_out.parent_index = out_parent_reg;
    assign msg_out.child_mask   = out_children_reg;

endmodule

### rtl/core/stpe_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the spanning-tree port engine, bound to its top level.
// Depends on stpe_pkg for the command codes.
module stpe_port_checks (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input stpe_pkg::port_t  send_port,
    input stpe_pkg::cmd_t   send_command,
    input logic             last_of_run,
    input logic             has_parent,
    input stpe_pkg::port_t  parent_index,
    input stpe_pkg::mask_t  child_mask
);
    import stpe_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(send_port)
        && $stable(send_command) && $stable(last_of_run) && $stable(child_mask))
        else $error("Stalled transfer changed.");

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("Input taken before the run finished.");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (send_command == CMD_ACCEPT || send_command == CMD_REJECT)
        |-> last_of_run)
        else $error("Reply to sender is not the final message of its run.");

    a_no_parent_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_parent |-> parent_index == '0)
        else $error("Parent index shown without a parent.");

endmodule

bind spanning_tree_port_engine stpe_port_checks u_stpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (msg_in.ready),
    .out_valid    (msg_out.valid),
    .out_ready    (msg_out.ready),
    .send_port    (msg_out.send_port),
    .send_command (msg_out.send_command),
    .last_of_run  (msg_out.last_of_run),
    .has_parent   (msg_out.has_parent),
    .parent_index (msg_out.parent_index),
    .child_mask   (msg_out.child_mask)
);
